/* rtl/lbsd_pkg.sv */
package lbsd_pkg;

	typedef struct packed {
		logic        active;
		logic        found;
		logic [15:0] least;
	} tok_t;

	typedef struct packed {
		logic [16:0] elapsed;
		logic [15:0] dur;
		logic        load;
		logic        excl_valid;
	} bcast_t;

endpackage

/* rtl/lbsd_cell.sv */
module lbsd_cell import lbsd_pkg::*; #(
	parameter int INDEX = 0,
	parameter int IDX_W = 4,
	parameter int CNT_W = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  tok_t             tok_in,
	input  logic [IDX_W-1:0] idx_in,
	input  bcast_t           bc,
	input  logic [IDX_W-1:0] excl_idx,
	input  logic [IDX_W-1:0] load_idx,
	input  logic [CNT_W-1:0] n_eff,
	output tok_t             tok_out,
	output logic [IDX_W-1:0] idx_out
);

	logic [15:0]      busy_q;
	logic [15:0]      busy_nxt;
	logic [15:0]      dec;
	logic [15:0]      post;
	logic             in_range;
	logic             excluded;
	logic             visit;
	logic             take;
	logic             tok_act_q;
	tok_t             tok_nxt;
	logic [IDX_W-1:0] idx_nxt;
	tok_t             tok_pl_q;
	logic [IDX_W-1:0] idx_q;

	always_comb begin
		in_range = CNT_W'(INDEX) < n_eff;
		excluded = bc.excl_valid && (excl_idx == IDX_W'(INDEX));
		visit    = tok_in.active && in_range;
		dec      = ({1'b0, busy_q} <= bc.elapsed) ? 16'd0 : (busy_q - bc.elapsed[15:0]);
		post     = excluded ? busy_q : dec;
		take     = visit && (busy_q == 16'd0) && !tok_in.found;

		if (bc.load && (load_idx == IDX_W'(INDEX))) begin
			busy_nxt = bc.dur;
		end else if (take) begin
			busy_nxt = bc.dur;
		end else if (visit && (busy_q != 16'd0)) begin
			busy_nxt = post;
		end else begin
			busy_nxt = busy_q;
		end

		tok_nxt = tok_in;
		idx_nxt = idx_in;
		if (visit) begin
			if (busy_q == 16'd0) begin
				if (!tok_in.found) begin
					tok_nxt.found = 1'b1;
					idx_nxt       = IDX_W'(INDEX);
				end
			end else if (!tok_in.found && ((INDEX == 0) || (post < tok_in.least))) begin
				tok_nxt.least = post;
				idx_nxt       = IDX_W'(INDEX);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 16'd0;
			tok_act_q <= 1'b0;
		end else begin
			busy_q    <= busy_nxt;
			tok_act_q <= tok_in.active;
		end
	end

	always_ff @(posedge clk) begin
		tok_pl_q <= tok_nxt;
		idx_q    <= idx_nxt;
	end

	always_comb begin
		tok_out        = tok_pl_q;
		tok_out.active = tok_act_q;
		idx_out        = idx_q;
	end

endmodule

/* rtl/least_busy_server_dispatcher_core.sv */
// channel | direction | handshake          | payload
// cfg     | in        | cfg_we             | cfg_wdata (server_count)
// in      | in        | in_valid/in_ready  | request_tag, gap, duration
// out     | out       | out_valid/out_ready| tag_out, server, start_time, delay
//
// one transaction at a time
// the scan token walks the cell chain one cell per cycle
// arst_n clears all busy times, both clocks and the exclusion at once
// a stalled out channel holds the finished result in the out register;
// the next transaction is taken meanwhile and waits only at its own result step
module least_busy_server_dispatcher_core import lbsd_pkg::*; #(
	parameter int MAX_SERVERS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] request_tag,
	input  logic [15:0] gap,
	input  logic [15:0] duration,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] tag_out,
	output logic [3:0]  server,
	output logic [31:0] start_time,
	output logic [31:0] delay
);

	localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam int CNT_W = ($clog2(MAX_SERVERS + 1) > 5) ? $clog2(MAX_SERVERS + 1) : 5;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_IDEAL = 3'd1;
	localparam logic [2:0] ST_ACT   = 3'd2;
	localparam logic [2:0] ST_ELAP  = 3'd3;
	localparam logic [2:0] ST_SCAN  = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;
	localparam logic [2:0] ST_RES   = 3'd6;

	function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	logic [2:0]       state_q;
	logic [4:0]       sc_q;
	logic [15:0]      tag_q;
	logic [15:0]      gap_q;
	logic [15:0]      dur_q;
	logic [31:0]      ideal_q;
	logic [31:0]      actual_q;
	logic [31:0]      prev_q;
	logic             found_last_q;
	logic             excl_valid_q;
	logic [IDX_W-1:0] excl_idx_q;
	logic             seed_q;
	logic [16:0]      elapsed_q;
	logic             fnd_q;
	logic [15:0]      least_q;
	logic [IDX_W-1:0] chosen_q;
	logic             load_q;
	logic             out_valid_q;
	logic [15:0]      tag_out_q;
	logic [3:0]       server_q;
	logic [31:0]      start_q;
	logic [31:0]      delay_q;

	logic [CNT_W-1:0] sc_w;
	logic [CNT_W-1:0] n_eff;
	logic [31:0]      diff;
	logic [IDX_W+3:0] srv_w;
	logic             res_fire;
	bcast_t           bc;
	tok_t             tok_w [0:MAX_SERVERS];
	logic [IDX_W-1:0] idx_w [0:MAX_SERVERS];

	always_comb begin
		sc_w = CNT_W'(sc_q);
		if (sc_w == '0) begin
			n_eff = CNT_W'(1);
		end else if (sc_w > CNT_W'(MAX_SERVERS)) begin
			n_eff = CNT_W'(MAX_SERVERS);
		end else begin
			n_eff = sc_w;
		end
		diff          = actual_q - prev_q;
		srv_w         = {4'b0000, chosen_q};
		res_fire      = (state_q == ST_RES) && (!out_valid_q || out_ready);
		bc.elapsed    = elapsed_q;
		bc.dur        = dur_q;
		bc.load       = load_q;
		bc.excl_valid = excl_valid_q;
	end

	assign tok_w[0].active = seed_q;
	assign tok_w[0].found  = 1'b0;
	assign tok_w[0].least  = 16'd0;
	assign idx_w[0]        = '0;

	// server chain
	for (genvar g = 0; g < MAX_SERVERS; g++) begin : g_cell
		lbsd_cell #(
			.INDEX(g),
			.IDX_W(IDX_W),
			.CNT_W(CNT_W)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok_w[g]),
			.idx_in  (idx_w[g]),
			.bc      (bc),
			.excl_idx(excl_idx_q),
			.load_idx(chosen_q),
			.n_eff   (n_eff),
			.tok_out (tok_w[g+1]),
			.idx_out (idx_w[g+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			sc_q         <= 5'd16;
			ideal_q      <= 32'd0;
			actual_q     <= 32'd0;
			prev_q       <= 32'd0;
			found_last_q <= 1'b1;
			excl_valid_q <= 1'b0;
			excl_idx_q   <= '0;
			seed_q       <= 1'b0;
			load_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			seed_q <= (state_q == ST_ELAP);
			load_q <= (state_q == ST_FIN) && !fnd_q;
			if (cfg_we) begin
				sc_q <= cfg_wdata;
			end
			if (res_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_IDEAL;
					end
				end
				ST_IDEAL: begin
					ideal_q <= sat_add32(ideal_q, {16'd0, gap_q});
					state_q <= ST_ACT;
				end
				ST_ACT: begin
					if (found_last_q) begin
						actual_q <= sat_add32(actual_q, {16'd0, gap_q});
					end else if (ideal_q > actual_q) begin
						actual_q <= ideal_q;
					end
					state_q <= ST_ELAP;
				end
				ST_ELAP: begin
					prev_q  <= actual_q;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (tok_w[MAX_SERVERS].active) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					found_last_q <= fnd_q;
					if (!fnd_q) begin
						actual_q     <= sat_add32(actual_q, {16'd0, least_q});
						excl_valid_q <= 1'b1;
						excl_idx_q   <= chosen_q;
					end else begin
						excl_valid_q <= 1'b0;
					end
					state_q <= ST_RES;
				end
				ST_RES: begin
					if (res_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			tag_q <= request_tag;
			gap_q <= gap;
			dur_q <= duration;
		end
		if (state_q == ST_ELAP) begin
			elapsed_q <= (diff[31:16] != 16'd0) ? 17'h10000 : {1'b0, diff[15:0]};
		end
		if (state_q == ST_SCAN && tok_w[MAX_SERVERS].active) begin
			fnd_q    <= tok_w[MAX_SERVERS].found;
			least_q  <= tok_w[MAX_SERVERS].least;
			chosen_q <= idx_w[MAX_SERVERS];
		end
		if (res_fire) begin
			tag_out_q <= tag_q;
			server_q  <= srv_w[3:0];
			start_q   <= actual_q;
			delay_q   <= (actual_q >= ideal_q) ? (actual_q - ideal_q) : 32'd0;
		end
	end

	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign tag_out    = tag_out_q;
	assign server     = server_q;
	assign start_time = start_q;
	assign delay      = delay_q;

endmodule

/* rtl/lbsd_checker.sv */
module lbsd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] tag_out,
	input logic [3:0]  server,
	input logic [31:0] start_time,
	input logic [31:0] delay
);

	// waiting delay never exceeds the actual clock
	a_delay_le_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (delay <= start_time))
		else $error("delay exceeds start_time");

	// one transaction in flight: no accept in the cycle after an accept
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("in_ready high right after accept");

	// an accept with no result pending is not answered before its compute states have run
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !out_valid) |=> ##2 !out_valid)
		else $error("result too early");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(tag_out) && $stable(server)
			&& $stable(start_time) && $stable(delay)))
		else $error("stalled result changed");

endmodule

bind least_busy_server_dispatcher_core lbsd_checker u_lbsd_checker (.*);

/* test/tb_least_busy_server_dispatcher_core.sv */
`timescale 1ns / 1ps

module tb_least_busy_server_dispatcher_core;

	localparam int NUM_SERVERS = 16;
	localparam int IDLE_MAX = 12;
	localparam int SETTLE_CYCLES = 30;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_JOBS = 70;

	typedef struct packed {
		logic [15:0] tag;
		logic [3:0]  server;
		logic [31:0] start;
		logic [31:0] wait_delay;
	} dispatch_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [4:0]  cfg_wdata = 5'd0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] request_tag = 16'd0;
	logic [15:0] gap = 16'd0;
	logic [15:0] duration = 16'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] tag_out;
	logic [3:0]  server;
	logic [31:0] start_time;
	logic [31:0] delay;

	// dispatcher state as seen from outside
	logic [15:0] busy_left [NUM_SERVERS] = '{default: 16'd0};
	logic [31:0] actual_clk = 32'd0;
	logic [31:0] prev_clk = 32'd0;
	logic [31:0] ideal_clk = 32'd0;
	bit          free_last = 1'b1;
	bit          excl_valid = 1'b0;
	int          excl_idx = 0;
	logic [4:0]  server_count_q = 5'd16;

	dispatch_t   dispatch_q [$];
	dispatch_t   expected_job;

	int errors = 0;
	int jobs_sent = 0;
	int results_seen = 0;
	int waited_dispatches = 0;
	int settings_used = 1;
	int hold_results = 0;
	int rx_wait = 0;
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;

	least_busy_server_dispatcher_core #(
		.MAX_SERVERS(NUM_SERVERS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.request_tag(request_tag),
		.gap(gap),
		.duration(duration),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.tag_out(tag_out),
		.server(server),
		.start_time(start_time),
		.delay(delay)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#1_000_000;
		$display("timeout with %0d transactions outstanding", dispatch_q.size());
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

	function automatic dispatch_t dispatch_job(logic [15:0] tag, logic [15:0] gp,
		logic [15:0] dur);
		dispatch_t r;
		int n;
		int pick;
		bit found;
		logic [31:0] elapsed;
		logic [15:0] least;
		if (server_count_q == 5'd0)
			n = 1;
		else if (server_count_q > NUM_SERVERS)
			n = NUM_SERVERS;
		else
			n = server_count_q;
		ideal_clk = sat_add32(ideal_clk, {16'd0, gp});
		if (free_last)
			actual_clk = sat_add32(actual_clk, {16'd0, gp});
		else if (ideal_clk > actual_clk)
			actual_clk = ideal_clk;
		elapsed = actual_clk - prev_clk;
		found = 1'b0;
		pick = 0;
		for (int i = 0; i < n; i++) begin
			if (busy_left[i] == 16'd0) begin
				if (!found) begin
					busy_left[i] = dur;
					found = 1'b1;
					pick = i;
				end
			end else if (!(excl_valid && excl_idx == i)) begin
				if ({16'd0, busy_left[i]} <= elapsed)
					busy_left[i] = 16'd0;
				else
					busy_left[i] = busy_left[i] - elapsed[15:0];
			end
		end
		excl_valid = 1'b0;
		prev_clk = actual_clk;
		if (!found) begin
			least = busy_left[0];
			pick = 0;
			for (int i = 1; i < n; i++) begin
				if (busy_left[i] < least) begin
					least = busy_left[i];
					pick = i;
				end
			end
			busy_left[pick] = dur;
			excl_valid = 1'b1;
			excl_idx = pick;
			actual_clk = sat_add32(actual_clk, {16'd0, least});
			waited_dispatches++;
		end
		free_last = found;
		r.tag = tag;
		r.server = 4'(pick);
		r.start = actual_clk;
		r.wait_delay = (actual_clk >= ideal_clk) ? actual_clk - ideal_clk : 32'd0;
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] exp_val,
		logic [31:0] act_val);
		if (exp_val !== act_val) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_val, act_val);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (dispatch_q.size() == 0) begin
				errors++;
				$display("%0t: result with no job outstanding, expected none, got tag %h",
					$time, tag_out);
			end else begin
				expected_job = dispatch_q.pop_front();
				check_field("tag_out", {16'd0, expected_job.tag}, {16'd0, tag_out});
				check_field("server", {28'd0, expected_job.server}, {28'd0, server});
				check_field("start_time", expected_job.start, start_time);
				check_field("delay", expected_job.wait_delay, delay);
			end
			rx_wait = rx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
		end
		if (hold_results > 0) begin
			hold_results--;
			out_ready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			out_ready <= 1'b0;
		end else
			out_ready <= 1'b1;
	end

	task automatic send_job(logic [15:0] tag, logic [15:0] gp, logic [15:0] dur);
		int idle;
		idle = tx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
		if (idle > 0) begin
			in_valid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		in_valid <= 1'b1;
		request_tag <= tag;
		gap <= gp;
		duration <= dur;
		do
			@(posedge clk);
		while (!in_ready);
		dispatch_q.push_back(dispatch_job(tag, gp, dur));
		jobs_sent++;
	endtask

	task automatic send_random_job();
		logic [15:0] gp;
		logic [15:0] dur;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: gp = 16'($urandom_range(0, 63));
			6, 7: gp = 16'($urandom_range(0, 4095));
			default: gp = 16'($urandom);
		endcase
		case ($urandom_range(0, 7))
			0: dur = 16'd0;
			1, 2: dur = 16'($urandom_range(1, 255));
			default: dur = 16'($urandom);
		endcase
		send_job(16'($urandom), gp, dur);
	endtask

	task automatic settle_block();
		in_valid <= 1'b0;
		while (dispatch_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_server_count(logic [4:0] value);
		settle_block();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		server_count_q = value;
		settings_used++;
	endtask

	task automatic test_directed_extremes();
		send_job(16'h0000, 16'h0000, 16'h0000);
		send_job(16'hFFFF, 16'hFFFF, 16'hFFFF);
		send_job(16'hAAAA, 16'h0000, 16'h5555);
		send_job(16'h5555, 16'h0001, 16'hAAAA);
		send_job(16'h1234, 16'h0000, 16'h0001);
		send_job(16'h8000, 16'h8000, 16'h8000);
	endtask

	task automatic test_single_server();
		write_server_count(5'd1);
		send_job(16'h0001, 16'h0000, 16'hFFFF);
		send_job(16'h0002, 16'h0000, 16'hFFFF);
		send_job(16'h0003, 16'h0000, 16'hFFFF);
		send_job(16'h0004, 16'hFFFF, 16'h0010);
		send_job(16'h0005, 16'h0000, 16'h0000);
	endtask

	task automatic test_exclusion_beyond_count();
		write_server_count(5'd2);
		send_job(16'h0010, 16'hFFFF, 16'd100);
		send_job(16'h0011, 16'h0000, 16'd50);
		send_job(16'h0012, 16'h0000, 16'd200);
		// server 1 is now held out of the next decrement but lies past the count
		write_server_count(5'd1);
		send_job(16'h0013, 16'h0000, 16'd10);
	endtask

	task automatic test_count_out_of_range();
		write_server_count(5'd0);
		send_job(16'h0020, 16'h0003, 16'h0007);
		send_job(16'h0021, 16'h0000, 16'h0009);
		write_server_count(5'd31);
		send_job(16'h0022, 16'h0002, 16'h0003);
		send_job(16'h0023, 16'h0000, 16'hFFFF);
		write_server_count(5'd17);
		send_job(16'h0024, 16'h0001, 16'h0002);
	endtask

	task automatic test_backpressure();
		write_server_count(5'd4);
		tx_idle_on = 1'b0;
		@(negedge clk);
		hold_results = HOLD_CYCLES;
		@(posedge clk);
		repeat (20) send_random_job();
		tx_idle_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		logic [4:0] counts [9];
		counts = '{5'd16, 5'd1, 5'd2, 5'd3, 5'd4, 5'd8, 5'd0, 5'd31, 5'd0};
		counts[8] = 5'($urandom_range(0, 31));
		for (int p = 0; p < 9; p++) begin
			write_server_count(counts[p]);
			tx_idle_on = !(p == 1 || p == 4);
			rx_idle_on = !(p == 2 || p == 4);
			repeat (PHASE_JOBS) send_random_job();
		end
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_single_server();
		test_exclusion_beyond_count();
		test_count_out_of_range();
		test_backpressure();
		test_random_traffic();
		settle_block();
		$display("%0d jobs over %0d server-count settings, %0d dispatched with no free server",
			jobs_sent, settings_used, waited_dispatches);
		$display("%0d results checked, %0d mismatches", results_seen, errors);
		if (errors == 0 && dispatch_q.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
